// ----- rtl/wfc_pkg.sv -----
`timescale 1ns / 1ps
package wfc_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;

  localparam logic [23:0] LLC_SNAP_HDR  = 24'hAAAA03;
  localparam logic [23:0] OUI_CDP       = 24'h00000C;
  localparam logic [23:0] OUI_ZERO      = 24'h000000;
  localparam logic [15:0] PID_CDP       = 16'h2000;
  localparam logic [15:0] PID_LLDP      = 16'h88CC;
  localparam logic [15:0] PID_IPV4      = 16'h0800;
  localparam logic [15:0] PORT_DHCP_SRV = 16'd67;
  localparam logic [15:0] PORT_DHCP_CLI = 16'd68;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  CNT_MAX       = 8'd255;
  localparam logic [12:0] HDR_LEN       = 13'd24;
  localparam logic [12:0] HDR_LEN_QOS   = 13'd26;
  localparam logic [11:0] POS_MAX       = 12'd4095;
  localparam logic [1:0]  FTYPE_DATA    = 2'd2;
  localparam logic [1:0]  DS_FOUR_ADDR  = 2'd3;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_REJECT   = 3'd0,
    ST_OTHER    = 3'd1,
    ST_CDP      = 3'd2,
    ST_LLDP     = 3'd3,
    ST_DHCP     = 3'd4,
    ST_FULL     = 3'd5,
    ST_READ_OK  = 3'd6,
    ST_READ_OOR = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CMD_REJECT = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_kind_e;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_CDP   = 2'd1,
    CLS_LLDP  = 2'd2,
    CLS_DHCP  = 2'd3
  } cls_e;

  typedef struct packed {
    cmd_kind_e   kind;
    cls_e        cls;
    logic [47:0] bssid;
    logic [5:0]  index;
  } cmd_t;

  typedef struct packed {
    logic [47:0] bssid;
    logic [7:0]  cdp;
    logic [7:0]  lldp;
    logic [7:0]  dhcp;
  } entry_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  slot;
    logic [47:0] bssid;
    logic [7:0]  cdp;
    logic [7:0]  lldp;
    logic [7:0]  dhcp;
    logic        new_entry;
  } res_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v != CNT_MAX) ? v + 8'd1 : v;
  endfunction

endpackage

// ----- rtl/wfc_front.sv -----
`timescale 1ns / 1ps
module wfc_front import wfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [5:0]  entry_index_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_ready_i
);

  logic [11:0] pos_q, pos_d;
  logic [15:0] fc_q, fc_d;
  logic [47:0] addr_q, addr_d;
  logic [63:0] llc_q, llc_d;
  logic [5:0]  ihl_q, ihl_d;
  logic [1:0]  flg_q, flg_d;
  logic [31:0] udp_q, udp_d;

  logic        acc;
  logic [12:0] idx, ao, hl, base, len, hn;
  logic        reject;
  cls_e        cls;
  logic        dhcp_ok;

  assign in_ready_o = cmd_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign idx        = {1'b0, pos_q};
  assign len        = idx + 13'd1;

  always_comb begin
    fc_d   = fc_q;
    addr_d = addr_q;
    llc_d  = llc_q;
    ihl_d  = ihl_q;
    flg_d  = flg_q;
    udp_d  = udp_q;
    case (fc_q[9:8])
      2'd0:    ao = 13'd16;
      2'd1:    ao = 13'd4;
      default: ao = 13'd10;
    endcase
    hl   = (fc_q[7:4] >= 4'd8) ? HDR_LEN_QOS : HDR_LEN;
    base = hl + 13'd8;
    if (idx == 13'd0) begin
      fc_d[7:0] = data_byte_i;
    end else if (idx == 13'd1) begin
      fc_d[15:8] = data_byte_i;
    end else begin
      if (idx >= ao && idx < ao + 13'd6) addr_d = {addr_q[39:0], data_byte_i};
      if (idx >= hl && idx < hl + 13'd8) llc_d = {llc_q[55:0], data_byte_i};
      if (idx == base) begin
        ihl_d    = {data_byte_i[3:0], 2'b00};
        flg_d[0] = (data_byte_i[7:4] == 4'd4);
      end
      if (idx == base + 13'd9) flg_d[1] = (data_byte_i == PROTO_UDP);
      if (ihl_d >= 6'd20 && idx >= base + 13'(ihl_d) && idx < base + 13'(ihl_d) + 13'd4)
        udp_d = {udp_q[23:0], data_byte_i};
    end
  end

  // verdict on the final byte, from the updated capture state
  always_comb begin
    hn      = (fc_d[7:4] >= 4'd8) ? HDR_LEN_QOS : HDR_LEN;
    reject  = (fc_d[3:2] != FTYPE_DATA) || (fc_d[9:8] == DS_FOUR_ADDR) ||
              (len < hn + 13'd8);
    dhcp_ok = (len >= hn + 13'd28) && flg_d[0] && (ihl_d >= 6'd20) &&
              (len >= hn + 13'd16 + 13'(ihl_d)) && flg_d[1] &&
              (udp_d[31:16] == PORT_DHCP_SRV || udp_d[31:16] == PORT_DHCP_CLI) &&
              (udp_d[15:0] == PORT_DHCP_SRV || udp_d[15:0] == PORT_DHCP_CLI);
    cls = CLS_OTHER;
    if (llc_d[63:40] == LLC_SNAP_HDR) begin
      if (llc_d[39:16] == OUI_CDP && llc_d[15:0] == PID_CDP) cls = CLS_CDP;
      else if (llc_d[39:16] == OUI_ZERO && llc_d[15:0] == PID_LLDP) cls = CLS_LLDP;
      else if (llc_d[39:16] == OUI_ZERO && llc_d[15:0] == PID_IPV4 && dhcp_ok)
        cls = CLS_DHCP;
    end
  end

  always_comb begin
    cmd_valid_o = 1'b0;
    cmd_o.kind  = reject ? CMD_REJECT : CMD_FRAME;
    cmd_o.cls   = cls;
    cmd_o.bssid = addr_d;
    cmd_o.index = entry_index_i;
    pos_d       = (pos_q != POS_MAX) ? pos_q + 12'd1 : pos_q;
    if (acc) begin
      case (op_i)
        OP_BYTE:  cmd_valid_o = last_byte_i;
        OP_CLEAR: begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = CMD_CLEAR;
        end
        OP_READ:  begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = CMD_READ;
        end
        default:  cmd_valid_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fc_q   <= '0;
      addr_q <= '0;
      llc_q  <= '0;
      ihl_q  <= '0;
      flg_q  <= '0;
      udp_q  <= '0;
    end else if (acc && op_i == OP_BYTE) begin
      if (last_byte_i) begin
        pos_q  <= '0;
        fc_q   <= '0;
        addr_q <= '0;
        llc_q  <= '0;
        ihl_q  <= '0;
        flg_q  <= '0;
        udp_q  <= '0;
      end else begin
        pos_q  <= pos_d;
        fc_q   <= fc_d;
        addr_q <= addr_d;
        llc_q  <= llc_d;
        ihl_q  <= ihl_d;
        flg_q  <= flg_d;
        udp_q  <= udp_d;
      end
    end
  end

endmodule

// ----- rtl/wfc_queue.sv -----
`timescale 1ns / 1ps
module wfc_queue import wfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_o,
  input  logic pop_ready_i
);

  cmd_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_o        = slot_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wp_q] <= push_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/wfc_back.sv -----
`timescale 1ns / 1ps
module wfc_back import wfc_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_ready_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output res_t        out_o,
  output logic [6:0]  entries_used_o
);

  localparam int unsigned IW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CW = $clog2(TableEntries + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SRD  = 7'b0000010,
    S_SCMP = 7'b0000100,
    S_UPD  = 7'b0001000,
    S_RRD  = 7'b0010000,
    S_RRES = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [CW-1:0]   i_q, i_d, used_q, used_d, used_out_q;
  logic [IW-1:0]   slot_q, slot_d, raddr;
  logic            new_q, new_d;
  entry_t          cur_q, cur_d, rdata_q, upd;
  res_t            res_q, res_d, out_q;
  logic            out_valid_q, out_free;
  logic            we;
  entry_t          mem_q [TableEntries];

  assign out_free       = !out_valid_q || out_ready_i;
  assign cmd_ready_o    = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out_o          = out_q;
  // entry count as of the result held in the output register
  assign entries_used_o = 7'(used_out_q);
  assign raddr          = (state_q == S_RRD) ? slot_q : i_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
    if (we) mem_q[slot_q] <= upd;
  end

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    i_d     = i_q;
    used_d  = used_q;
    slot_d  = slot_q;
    new_d   = new_q;
    cur_d   = cur_q;
    res_d   = res_q;
    we      = 1'b0;
    upd     = cur_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          i_d   = '0;
          res_d = '0;
          case (cmd_i.kind)
            CMD_REJECT: begin
              res_d.status = ST_REJECT;
              state_d      = S_EMIT;
            end
            CMD_FRAME: state_d = S_SRD;
            CMD_CLEAR: used_d = '0;
            CMD_READ: begin
              if (9'(cmd_i.index) < 9'(used_q)) begin
                slot_d  = IW'(cmd_i.index);
                state_d = S_RRD;
              end else begin
                res_d.status = ST_READ_OOR;
                res_d.slot   = cmd_i.index;
                state_d      = S_EMIT;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // linear search, one entry per S_SRD/S_SCMP state pair
      S_SRD: begin
        if (i_q == used_q) begin
          if (used_q >= CW'(TableEntries)) begin
            res_d.status = ST_FULL;
            res_d.bssid  = cmd_q.bssid;
            state_d      = S_EMIT;
          end else begin
            slot_d  = used_q[IW-1:0];
            cur_d   = '0;
            cur_d.bssid = cmd_q.bssid;
            new_d   = 1'b1;
            state_d = S_UPD;
          end
        end else begin
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (rdata_q.bssid == cmd_q.bssid) begin
          slot_d  = i_q[IW-1:0];
          cur_d   = rdata_q;
          new_d   = 1'b0;
          state_d = S_UPD;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_SRD;
        end
      end
      S_UPD: begin
        res_d.status = ST_OTHER;
        case (cmd_q.cls)
          CLS_CDP: begin
            upd.cdp      = sat_inc(cur_q.cdp);
            res_d.status = ST_CDP;
          end
          CLS_LLDP: begin
            upd.lldp     = sat_inc(cur_q.lldp);
            res_d.status = ST_LLDP;
          end
          CLS_DHCP: begin
            upd.dhcp     = sat_inc(cur_q.dhcp);
            res_d.status = ST_DHCP;
          end
          default: res_d.status = ST_OTHER;
        endcase
        we              = 1'b1;
        res_d.slot      = 6'(slot_q);
        res_d.bssid     = upd.bssid;
        res_d.cdp       = upd.cdp;
        res_d.lldp      = upd.lldp;
        res_d.dhcp      = upd.dhcp;
        res_d.new_entry = new_q;
        if (new_q) used_d = used_q + CW'(1);
        state_d = S_EMIT;
      end
      S_RRD: state_d = S_RRES;
      S_RRES: begin
        res_d.status    = ST_READ_OK;
        res_d.slot      = 6'(slot_q);
        res_d.bssid     = rdata_q.bssid;
        res_d.cdp       = rdata_q.cdp;
        res_d.lldp      = rdata_q.lldp;
        res_d.dhcp      = rdata_q.dhcp;
        res_d.new_entry = 1'b0;
        state_d         = S_EMIT;
      end
      S_EMIT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    i_q    <= i_d;
    slot_q <= slot_d;
    new_q  <= new_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
    if (state_q == S_EMIT && out_free) begin
      out_q      <= res_q;
      used_out_q <= used_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (state_q == S_EMIT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)              out_valid_q <= 1'b0;
    end
  end

endmodule

// ----- rtl/wlan_data_frame_l2l3_classifier.sv -----
`timescale 1ns / 1ps
// Channel | Handshake                  | Payload
// in      | in_valid_i / in_ready_o    | op_i, data_byte_i, last_byte_i, entry_index_i
// out     | out_valid_o / out_ready_i  | status_o, entry_slot_o, bssid_o, *_total_o,
//         |                            | new_entry_o, entries_used_o
//
// Frame bytes are taken one per cycle while the 2-deep command queue has room.
// Table lookup is a linear search (one table read per compare, S_SRD then
// S_SCMP per entry); reads pass S_RRD and S_RRES, rejects go straight to S_EMIT.
// Reset empties the table at once (entry count to zero); no clearing pass.
// A stalled output holds the back end; the front keeps parsing until the
// queue fills.
module wlan_data_frame_l2l3_classifier import wfc_pkg::*; #(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [5:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [5:0]  entry_slot_o,
  output logic [47:0] bssid_o,
  output logic [7:0]  cdp_total_o,
  output logic [7:0]  lldp_total_o,
  output logic [7:0]  dhcp_total_o,
  output logic        new_entry_o,
  output logic [6:0]  entries_used_o
);

  cmd_t fq_cmd, qb_cmd;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  res_t res;

  // front: parses bytes, issues one command per frame / clear / read
  wfc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .data_byte_i,
    .last_byte_i, .entry_index_i,
    .cmd_valid_o(fq_valid), .cmd_o(fq_cmd), .cmd_ready_i(fq_ready)
  );

  wfc_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(fq_valid), .push_i(fq_cmd), .push_ready_o(fq_ready),
    .pop_valid_o(qb_valid), .pop_o(qb_cmd), .pop_ready_i(qb_ready)
  );

  // back: table search / allocate / count, clear and read, registered result
  wfc_back #(.TableEntries(TableEntries)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(qb_valid), .cmd_i(qb_cmd), .cmd_ready_o(qb_ready),
    .out_ready_i, .out_valid_o, .out_o(res), .entries_used_o
  );

  assign status_o     = res.status;
  assign entry_slot_o = res.slot;
  assign bssid_o      = res.bssid;
  assign cdp_total_o  = res.cdp;
  assign lldp_total_o = res.lldp;
  assign dhcp_total_o = res.dhcp;
  assign new_entry_o  = res.new_entry;

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_READ_OK |-> 7'(entry_slot_o) < entries_used_o)
    else $error("read ok beyond used entries");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> 9'(entries_used_o) == 9'(TableEntries))
    else $error("table full reported with free entries");

  a_new_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && new_entry_o |-> 7'(entry_slot_o) + 7'd1 == entries_used_o)
    else $error("new entry is not the last allocated");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_REJECT |-> bssid_o == '0 && !new_entry_o)
    else $error("rejected frame carries data");

endmodule
